// File: sv/grayscale_bit_depth_row_packer_defines.svh
// ----------------------------------------------------------------------------
// Row packer assertion macros
// Shared concurrent assertion forms, clocked on clk_i, held off in reset.
// ----------------------------------------------------------------------------
`ifndef GRAYSCALE_BIT_DEPTH_ROW_PACKER_DEFINES_SVH
`define GRAYSCALE_BIT_DEPTH_ROW_PACKER_DEFINES_SVH

// Same-cycle implication.
`define GBRP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("row packer: same-cycle check failed");

// Next-cycle implication.
`define GBRP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("row packer: next-cycle check failed");

`endif

// File: sv/gbrp_pkg.sv
// ----------------------------------------------------------------------------
// Row packer package
// Shared widths, register indexes, depth codes and the job record.
// ----------------------------------------------------------------------------
`default_nettype none

package gbrp_pkg;

  localparam int unsigned DEF_MAX_ROW_WIDTH = 4096;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WIDTH_W = 13;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned PAD_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE = 2'd1;

  localparam logic [MODE_W-1:0] MODE_1BPP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_2BPP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_4BPP = 2'd2;

  // One packed byte plus the pad bytes that follow it.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic [PAD_W-1:0]  pads;
    logic              row_end;
  } job_t;

endpackage

`default_nettype wire

// File: sv/gbrp_pixel_if.sv
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one 8-bit grayscale pixel per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbrp_pixel_if import gbrp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

`default_nettype wire

// File: sv/gbrp_byte_if.sv
// ----------------------------------------------------------------------------
// Packed byte channel
// Valid/ready channel carrying one packed byte and its row marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbrp_byte_if import gbrp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] packed_byte;
  logic              row_done;

  modport source (output valid, output packed_byte, output row_done, input ready);
  modport sink   (input valid, input packed_byte, input row_done, output ready);
endinterface

`default_nettype wire

// File: sv/gbrp_packer.sv
// ----------------------------------------------------------------------------
// Row packer front end
// Holds configuration and row state; folds pixels into bytes, one job per completed byte.
// ----------------------------------------------------------------------------
`default_nettype none

module gbrp_packer
  import gbrp_pkg::*;
#(
  parameter int unsigned MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  gbrp_pixel_if.sink                 pix_i,
  input  wire logic                  take_ok_i,
  output job_t                       job_o
);

  localparam int unsigned CW   = $clog2(MAX_ROW_WIDTH + 1);
  localparam int unsigned CMPW = (CW > WIDTH_W) ? CW : WIDTH_W;

  logic [WIDTH_W-1:0] width_q;
  logic [MODE_W-1:0]  mode_q;
  logic [BYTE_W-1:0]  acc_q, acc_d;
  logic [2:0]         npix_q, npix_d;
  logic [CW-1:0]      col_q, col_d;
  logic [1:0]         phase_q, phase_d;

  logic              xfer;
  logic [BYTE_W-1:0] placed;
  logic [BYTE_W-1:0] acc_new;
  logic [3:0]        npix_new;
  logic [3:0]        per_byte;
  logic              full;
  logic [CMPW-1:0]   col_new;
  logic [CMPW-1:0]   eff_width;
  logic              row_end;
  logic              emit;
  logic [1:0]        phase_emit;

  assign pix_i.ready = take_ok_i;
  assign xfer        = pix_i.valid && take_ok_i;

  always_comb begin
    unique case (mode_q)
      MODE_1BPP: begin
        placed   = {pix_i.pixel_value[7], 7'b0} >> npix_q;
        per_byte = 4'd8;
      end
      MODE_2BPP: begin
        placed   = {pix_i.pixel_value[7:6], 6'b0} >> {npix_q, 1'b0};
        per_byte = 4'd4;
      end
      default: begin
        // mode three behaves as four bits per pixel
        placed   = {pix_i.pixel_value[7:4], 4'b0} >> {npix_q, 2'b0};
        per_byte = 4'd2;
      end
    endcase
  end

  always_comb begin
    if (width_q == '0) begin
      eff_width = CMPW'(1);
    end else if (CMPW'(width_q) > CMPW'(MAX_ROW_WIDTH)) begin
      eff_width = CMPW'(MAX_ROW_WIDTH);
    end else begin
      eff_width = CMPW'(width_q);
    end
  end

  assign acc_new    = acc_q | placed;
  assign npix_new   = {1'b0, npix_q} + 4'd1;
  assign full       = (npix_new == per_byte);
  assign col_new    = CMPW'(col_q) + CMPW'(1);
  assign row_end    = (col_new >= eff_width);
  assign emit       = full || row_end;
  assign phase_emit = phase_q + 2'(emit);

  always_comb begin
    acc_d   = acc_q;
    npix_d  = npix_q;
    col_d   = col_q;
    phase_d = phase_q;
    if (xfer) begin
      acc_d   = emit ? '0 : acc_new;
      npix_d  = emit ? 3'd0 : npix_new[2:0];
      col_d   = row_end ? '0 : col_new[CW-1:0];
      phase_d = row_end ? 2'd0 : phase_emit;
    end
  end

  always_comb begin
    job_o.valid   = xfer && emit;
    job_o.data    = acc_new;
    job_o.pads    = row_end ? (2'd0 - phase_emit) : 2'd0;
    job_o.row_end = row_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_W'(1);
      mode_q  <= MODE_1BPP;
      acc_q   <= '0;
      npix_q  <= '0;
      col_q   <= '0;
      phase_q <= '0;
    end else if (cfg_we_i) begin
      // a write to the width or depth register drops a partly taken row
      if (cfg_idx_i == REG_ROW_WIDTH) begin
        width_q <= cfg_wdata_i[WIDTH_W-1:0];
        acc_q   <= '0;
        npix_q  <= '0;
        col_q   <= '0;
        phase_q <= '0;
      end else if (cfg_idx_i == REG_DEPTH_MODE) begin
        mode_q  <= cfg_wdata_i[MODE_W-1:0];
        acc_q   <= '0;
        npix_q  <= '0;
        col_q   <= '0;
        phase_q <= '0;
      end
    end else begin
      acc_q   <= acc_d;
      npix_q  <= npix_d;
      col_q   <= col_d;
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/gbrp_emitter.sv
// ----------------------------------------------------------------------------
// Row packer output stage
// Result register that sends a job's byte, then its zero pad bytes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grayscale_bit_depth_row_packer_defines.svh"

module gbrp_emitter
  import gbrp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire job_t  job_i,
  output logic       take_ok_o,
  gbrp_byte_if.source byte_o
);

  logic              busy_q;
  logic [BYTE_W-1:0] byte_q;
  logic [PAD_W-1:0]  pads_q;
  logic              row_end_q;
  logic              out_xfer;
  logic              last_out;

  assign out_xfer  = busy_q && byte_o.ready;
  assign last_out  = (pads_q == '0);
  assign take_ok_o = !busy_q || (out_xfer && last_out);

  assign byte_o.valid       = busy_q;
  assign byte_o.packed_byte = byte_q;
  assign byte_o.row_done    = row_end_q && last_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pads_q <= '0;
    end else if (job_i.valid) begin
      busy_q <= 1'b1;
      pads_q <= job_i.pads;
    end else if (out_xfer) begin
      if (last_out) begin
        busy_q <= 1'b0;
      end else begin
        pads_q <= pads_q - PAD_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_i.valid) begin
      byte_q    <= job_i.data;
      row_end_q <= job_i.row_end;
    end else if (out_xfer && !last_out) begin
      byte_q <= '0;
    end
  end

  `GBRP_ASSERT_IMP(a_no_overwrite, job_i.valid, !busy_q || (byte_o.ready && pads_q == '0))
  `GBRP_ASSERT_NXT(a_pad_zero, out_xfer && pads_q != '0, busy_q && byte_q == '0)
  `GBRP_ASSERT_NXT(a_job_loaded, job_i.valid, busy_q && byte_q == $past(job_i.data))

endmodule

`default_nettype wire

// File: sv/grayscale_bit_depth_row_packer.sv
// Latency: a byte appears on byte_o the cycle after the pixel transfer that completes it.
// Throughput: one pixel per cycle while byte_o is ready; a row end with pad bytes holds
//   pix_i while the output register sends the zero pad bytes.
// Reset: asynchronous, active low; clears row state, sets width 1 and one bit per pixel.
// ----------------------------------------------------------------------------
// Grayscale bit depth row packer
// Packs 8-bit grayscale pixels to 1, 2 or 4 bits each, MSB first, and pads
// every row to a multiple of four bytes, marking the last byte of the row.
// ----------------------------------------------------------------------------
`default_nettype none

module grayscale_bit_depth_row_packer
  import gbrp_pkg::*;
#(
  parameter int unsigned MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  gbrp_pixel_if.sink                 pix_i,
  gbrp_byte_if.source                byte_o
);

  // Job handed from the pixel front end to the output register: the byte
  // completed by this pixel (full, or flushed with zero fill at row end),
  // how many zero pad bytes follow it, and whether it closes a row.
  job_t job;

  // High when the output register can take a new job this cycle: it is
  // empty, or its final byte is leaving now. Pixels are taken only then,
  // so a pixel that completes no byte still waits on a draining row end.
  logic take_ok;

  // Front end: configuration registers, bit accumulator, column and
  // byte phase counters. Per-pixel work is a short shift and OR, a column count and compare.
  gbrp_packer #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_i),
    .take_ok_i   (take_ok),
    .job_o       (job)
  );

  // Output register: send the data byte, then advance through pad bytes,
  // raising row_done on the final transfer of a row.
  gbrp_emitter u_emitter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (job),
    .take_ok_o (take_ok),
    .byte_o    (byte_o)
  );

endmodule

`default_nettype wire

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// Row packer testbench
// Streams grayscale pixels through the packer at several widths and depths,
// predicts every packed byte, pad byte and row marker in a scoreboard, and
// compares each byte transfer with the oldest prediction. Both channels idle
// at random, with a long receiver hold-off and a stretch at full rate.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import gbrp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HALF_PERIOD   = 5;
  localparam int unsigned RESET_CYCLES  = 5;
  // A byte is registered after its pixel and may be followed by up to three pad bytes.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS  = 180;
  localparam int unsigned HOLD_OFF_LEN  = 80;
  localparam int unsigned IDLE_PERCENT  = 30;
  localparam int unsigned RUN_LIMIT     = 200000;

  // Register slots past the last real register; writes to them must do nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              row_done;
  } out_byte_t;

  // Predicts the packed byte stream and holds the bytes still owed by the block.
  class packer_scoreboard;
    logic [WIDTH_W-1:0] row_width;
    logic [MODE_W-1:0]  depth;
    logic [BYTE_W-1:0]  acc;
    int unsigned        pix_in_byte;
    int unsigned        column;
    logic [1:0]         byte_phase;
    out_byte_t          pending[$];
    int unsigned        errors;

    function new();
      row_width = WIDTH_W'(1);
      depth     = MODE_1BPP;
      errors    = 0;
      clear_row();
    endfunction

    function void clear_row();
      acc         = '0;
      pix_in_byte = 0;
      column      = 0;
      byte_phase  = '0;
    endfunction

    function int unsigned effective_width();
      if (row_width == 0) return 1;
      if (row_width > DEF_MAX_ROW_WIDTH) return DEF_MAX_ROW_WIDTH;
      return 32'(row_width);
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      if (idx == REG_ROW_WIDTH) begin
        row_width = data[WIDTH_W-1:0];
        clear_row();
      end else if (idx == REG_DEPTH_MODE) begin
        depth = data[MODE_W-1:0];
        clear_row();
      end
    endfunction

    function void push_byte(input logic [BYTE_W-1:0] data);
      out_byte_t b;
      b.data     = data;
      b.row_done = 1'b0;
      pending.push_back(b);
      byte_phase = byte_phase + 2'd1;
    endfunction

    // Fold one accepted pixel into the byte under construction, queueing any finished byte and row-end pads.
    function void note_pixel(input logic [PIX_W-1:0] pixel);
      int unsigned bpp;
      int unsigned bits;
      int unsigned shift;
      int unsigned made;
      made = 0;
      if (depth == MODE_1BPP)      bpp = 1;
      else if (depth == MODE_2BPP) bpp = 2;
      else                         bpp = 4;
      bits  = 32'(pixel) >> (8 - bpp);
      shift = 8 - bpp * (pix_in_byte + 1);
      acc   = acc | BYTE_W'(bits << shift);
      pix_in_byte++;
      if (pix_in_byte >= 8 / bpp) begin
        push_byte(acc);
        made++;
        acc         = '0;
        pix_in_byte = 0;
      end
      column++;
      if (column >= effective_width()) begin
        if (pix_in_byte != 0) begin
          push_byte(acc);
          made++;
          acc         = '0;
          pix_in_byte = 0;
        end
        while (byte_phase != 0) begin
          push_byte('0);
          made++;
        end
        if (made > 0) pending[pending.size()-1].row_done = 1'b1;
        column = 0;
      end
    endfunction

    task report_mismatch(input string msg);
      errors++;
      $display("[%0t] packer check: %s", $realtime, msg);
    endtask

    task check_byte(input logic [BYTE_W-1:0] data, input logic done);
      out_byte_t exp;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("byte %02h row_done %0b with none owed", data, done));
        return;
      end
      exp = pending.pop_front();
      if (data !== exp.data)
        report_mismatch($sformatf("packed_byte %02h, predicted %02h", data, exp.data));
      if (done !== exp.row_done)
        report_mismatch($sformatf("row_done %0b, predicted %0b on byte %02h",
                                  done, exp.row_done, exp.data));
    endtask

    task finish_check();
      if (pending.size() != 0)
        report_mismatch($sformatf("%0d bytes never arrived", pending.size()));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Channel pacing: calm drops all random idling, hold_off_req asks the
  // receiver for one long stall.
  bit          calm = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned cycle_count = 0;

  packer_scoreboard sb = new();

  gbrp_pixel_if pix_if();
  gbrp_byte_if  byte_if();

  grayscale_bit_depth_row_packer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pix_i       (pix_if),
    .byte_o      (byte_if)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Hold the register write until it is sampled; the caller drops cfg_we after
  // its last write so that the enable is never lowered and raised in one step.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Write width and depth, junk in the unused upper bits of the depth word.
  task automatic configure(input int unsigned width, input logic [MODE_W-1:0] mode,
                           input bit add_spare);
    logic [CFG_DATA_W-1:0] mode_word;
    mode_word = CFG_DATA_W'($urandom);
    mode_word[MODE_W-1:0] = mode;
    if (add_spare) cfg_write(REG_SPARE_2, CFG_DATA_W'($urandom));
    cfg_write(REG_ROW_WIDTH, width[CFG_DATA_W-1:0]);
    cfg_write(REG_DEPTH_MODE, mode_word);
    if (add_spare) cfg_write(REG_SPARE_3, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Offer one pixel, idling first at random, and return at the falling edge
  // after its transfer.
  task automatic send_pixel(input logic [PIX_W-1:0] value);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PERCENT) begin
        pix_if.valid       <= 1'b0;
        pix_if.pixel_value <= PIX_W'($urandom);
        @(negedge clk_i);
      end
    end
    pix_if.valid       <= 1'b1;
    pix_if.pixel_value <= value;
    do @(posedge clk_i); while (!pix_if.ready);
    sb.note_pixel(value);
    @(negedge clk_i);
  endtask

  // Stop offering, wait for every owed byte, then let the block settle
  // before it is touched again.
  task automatic drain_results();
    pix_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Compare every byte transfer as it happens.
  always @(posedge clk_i) begin
    if (rst_ni && byte_if.valid && byte_if.ready)
      sb.check_byte(byte_if.packed_byte, byte_if.row_done);
  end

  // Receiver: idle at random, drop ready entirely for one long stretch on
  // request, and run at full rate while calm.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left     = 0;
    hold_done     = 1'b0;
    byte_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_done) begin
        hold_left = HOLD_OFF_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        byte_if.ready <= 1'b0;
      end else begin
        byte_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("[%0t] packer check: run limit reached", $realtime);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned   random_items;
    int unsigned   phase;
    int unsigned   width;
    int unsigned   span;
    int unsigned   count;
    logic [MODE_W-1:0] mode;
    logic [PIX_W-1:0]  pixel;

    pix_if.valid       = 1'b0;
    pix_if.pixel_value = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: one-pixel rows at one bit, so every pixel gives a
    // byte and three pads.
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h80);
    send_pixel(8'h7F);
    drain_results();

    // Width beyond the maximum clips, depth code three acts as four bits;
    // the odd pixel stays in the accumulator and is dropped by the next write.
    configure(8191, 2'd3, 1'b0);
    send_pixel(8'hF0);
    send_pixel(8'h0F);
    send_pixel(8'hAA);
    send_pixel(8'h55);
    send_pixel(8'hFF);
    drain_results();

    // Zero width acts as one pixel per row.
    configure(0, MODE_2BPP, 1'b0);
    send_pixel(8'hC0);
    send_pixel(8'h3F);
    drain_results();

    // Writes to the spare slots mid-row must leave the row intact.
    configure(5, MODE_2BPP, 1'b0);
    send_pixel(8'h40);
    send_pixel(8'h80);
    send_pixel(8'hC0);
    drain_results();
    cfg_write(REG_SPARE_2, CFG_DATA_W'($urandom));
    cfg_write(REG_SPARE_3, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    send_pixel(8'hFF);
    send_pixel(8'h01);
    drain_results();

    // Widest legal row at four bits, partly filled and then dropped.
    configure(DEF_MAX_ROW_WIDTH, MODE_4BPP, 1'b0);
    repeat (6) send_pixel(PIX_W'($urandom));
    drain_results();

    // Random phases: mostly whole rows of small widths, now and then a stray
    // partial row, a clipped or zero width, or spare-slot writes.
    random_items = 0;
    phase        = 0;
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       width = 0;
        1:       width = DEF_MAX_ROW_WIDTH;
        2:       width = $urandom_range(DEF_MAX_ROW_WIDTH + 1, 8191);
        3:       width = 1;
        default: width = $urandom_range(2, 40);
      endcase
      mode = MODE_W'($urandom_range(0, 3));
      if (phase == 0) begin
        // Enough bytes to fill the block while the receiver holds off.
        width = 16;
        mode  = MODE_4BPP;
      end else if (phase == 2) begin
        width = 12;
      end
      configure(width, mode, $urandom_range(0, 3) == 0);
      span = sb.effective_width();
      if (span > 64) begin
        count = $urandom_range(8, 40);
      end else begin
        count = span * $urandom_range(1, 3);
        if (span > 1 && $urandom_range(0, 4) == 0) count += $urandom_range(1, span - 1);
      end
      hold_off_req = (phase == 0);
      calm         = (phase == 2);
      repeat (count) begin
        case ($urandom_range(0, 7))
          0:       pixel = '0;
          1:       pixel = '1;
          default: pixel = PIX_W'($urandom);
        endcase
        send_pixel(pixel);
        random_items++;
      end
      drain_results();
      calm = 1'b0;
      phase++;
    end

    sb.finish_check();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
